### src/slad_pkg.sv
// Shared widths, constants and stage types for the segment length/angle block.
// No dependencies; every other file refers to it by scoped names.
package slad_pkg;

  // field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned TolW   = 16;
  localparam int unsigned LenW   = 41;
  localparam int unsigned AngW   = 25;
  localparam int unsigned DirW   = 3;

  // length path: sum of squares, radicand and digit-by-digit root
  localparam int unsigned LenFrac  = 8;
  localparam int unsigned SqW      = 2 * DiffW;
  localparam int unsigned RadW     = SqW + 2 * LenFrac;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned SqrtSteps = RootW;

  // angle path: vectoring rotator in 2^-24 degree
  localparam int unsigned XyW        = 64;
  localparam int unsigned ZW         = 32;
  localparam int unsigned ZFrac      = 24;
  localparam int unsigned AngFrac    = 16;
  localparam int unsigned A24W       = 33;
  localparam int unsigned CordicSteps = 26;

  // stages of the iteration chain that finish the angle
  localparam int unsigned OctStep   = CordicSteps;
  localparam int unsigned QuadStep  = CordicSteps + 1;
  localparam int unsigned RoundStep = CordicSteps + 2;

  localparam logic signed [ZW-1:0] Deg45Z = 32'sd754974720;
  localparam logic signed [A24W:0] Deg90W  = 34'sd1509949440;
  localparam logic signed [A24W:0] Deg180W = 34'sd3019898880;
  localparam logic signed [A24W:0] Deg360W = 34'sd6039797760;
  localparam logic [AngW:0]        Full360 = 26'd23592960;
  localparam logic [AngW-1:0]      Half180 = 25'd11796480;
  localparam logic [A24W:0]        RoundHalf = 34'd128;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic signed [ZW-1:0] AtanTab [CordicSteps] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938, 32'sd60000934,
    32'sd30029717, 32'sd15018523, 32'sd7509720, 32'sd3754917, 32'sd1877466,
    32'sd938734, 32'sd469367, 32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
    32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833, 32'sd917, 32'sd458, 32'sd229,
    32'sd115, 32'sd57, 32'sd29
  };

  // integer-degree marks of the direction codes
  localparam logic [8:0] Deg0   = 9'd0;
  localparam logic [8:0] Deg45  = 9'd45;
  localparam logic [8:0] Deg90  = 9'd90;
  localparam logic [8:0] Deg135 = 9'd135;
  localparam logic [8:0] Deg180 = 9'd180;
  localparam logic [8:0] Deg225 = 9'd225;
  localparam logic [8:0] Deg270 = 9'd270;
  localparam logic [8:0] Deg315 = 9'd315;

  // per-item side data that rides along the iteration chain
  typedef struct packed {
    logic                   same;
    logic                   dx_neg;
    logic                   dy_neg;
    logic                   swap;
    logic                   small_zero;
    logic                   diag;
    logic signed [ZW-1:0]   z;
    logic [A24W-1:0]        a24;
    logic [AngW-1:0]        ang;
  } side_t;

endpackage

### src/slad_if.sv
// Channel interfaces: segment input, result output and tolerance write.
// Depends on slad_pkg for field widths.
interface slad_seg_if;
  logic                               valid;
  logic                               ready;
  logic signed [slad_pkg::CoordW-1:0] head_x;
  logic signed [slad_pkg::CoordW-1:0] head_y;
  logic signed [slad_pkg::CoordW-1:0] tail_x;
  logic signed [slad_pkg::CoordW-1:0] tail_y;
  modport source (output valid, head_x, head_y, tail_x, tail_y, input ready);
  modport sink (input valid, head_x, head_y, tail_x, tail_y, output ready);
endinterface

interface slad_res_if;
  logic                         valid;
  logic                         ready;
  logic [slad_pkg::LenW-1:0]    seg_length;
  logic [slad_pkg::AngW-1:0]    seg_angle;
  logic [slad_pkg::DirW-1:0]    direction_code;
  logic                         same_point;
  modport source (output valid, seg_length, seg_angle, direction_code, same_point,
                  input ready);
  modport sink (input valid, seg_length, seg_angle, direction_code, same_point,
                output ready);
endinterface

interface slad_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [slad_pkg::TolW-1:0]  same_point_tolerance;
  modport source (output valid, same_point_tolerance, input ready);
  modport sink (input valid, same_point_tolerance, output ready);
endinterface

### src/segment_length_angle_direction.sv
// Pipeline: the result passes 47 register stages after the input transfer:
// 5 front stages, 41 root-digit stages that also host the 26 rotator steps, one output stage.
// Throughput: one segment per cycle; a stalled output freezes the whole pipeline.
// Reset: valid bits clear and the tolerance register returns to 0.
// Depends on slad_pkg, slad_if and slad_sqrt_step.
module segment_length_angle_direction (
  input  logic     clk_i,
  input  logic     rst_ni,
  slad_cfg_if.sink cfg_i,
  slad_seg_if.sink in_i,
  slad_res_if.source out_o
);

  localparam int unsigned NIt = slad_pkg::SqrtSteps;
  localparam int unsigned NCo = slad_pkg::CordicSteps;

  logic adv;
  logic [slad_pkg::TolW-1:0] tol_q;

  // front stage registers
  logic va_q, vb_q, vc_q, vd_q;
  logic signed [slad_pkg::DiffW-1:0] dx_q, dy_q;
  logic [slad_pkg::DiffW-1:0] ax_q, ay_q;
  logic bdx_neg_q, bdy_neg_q;
  logic [slad_pkg::SqW-1:0] sqx_q, sqy_q, sum_q;
  logic [slad_pkg::XyW-1:0] big_c_q, small_c_q, big_d_q, small_d_q;
  slad_pkg::side_t side_c_d, side_c_q, side_d_q;

  // iteration chain, index 0 is the last front stage
  logic                         it_v_q  [NIt+1];
  logic [slad_pkg::RadW-1:0]    rad_q   [NIt+1];
  logic [slad_pkg::RemW-1:0]    rem_q   [NIt+1];
  logic [slad_pkg::RootW-1:0]   root_q  [NIt+1];
  slad_pkg::side_t              side_q  [NIt+1];
  logic signed [slad_pkg::XyW-1:0] x_q  [NCo+1];
  logic signed [slad_pkg::XyW-1:0] y_q  [NCo+1];

  // output register
  logic                          out_v_q;
  logic [slad_pkg::LenW-1:0]     len_q;
  logic [slad_pkg::AngW-1:0]     ang_q;
  logic [slad_pkg::DirW-1:0]     dir_q;
  logic                          same_q;

  assign adv         = !out_v_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.same_point_tolerance;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      it_v_q[0] <= 1'b0;
    end else if (adv) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      it_v_q[0] <= vd_q;
    end
  end

  // stage A: coordinate differences
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= {in_i.tail_x[slad_pkg::CoordW-1], in_i.tail_x}
            - {in_i.head_x[slad_pkg::CoordW-1], in_i.head_x};
      dy_q <= {in_i.tail_y[slad_pkg::CoordW-1], in_i.tail_y}
            - {in_i.head_y[slad_pkg::CoordW-1], in_i.head_y};
    end
  end

  // stage B: magnitudes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q      <= dx_q[slad_pkg::DiffW-1] ? (~dx_q + 1'b1) : dx_q;
      ay_q      <= dy_q[slad_pkg::DiffW-1] ? (~dy_q + 1'b1) : dy_q;
      bdx_neg_q <= dx_q[slad_pkg::DiffW-1];
      bdy_neg_q <= dy_q[slad_pkg::DiffW-1];
    end
  end

  // stage C: squares, octant fold and special cases
  always_comb begin
    logic swap;
    swap = ay_q > ax_q;
    side_c_d = '0;
    side_c_d.same = (ax_q <= {{(slad_pkg::DiffW-slad_pkg::TolW){1'b0}}, tol_q})
                 && (ay_q <= {{(slad_pkg::DiffW-slad_pkg::TolW){1'b0}}, tol_q});
    side_c_d.dx_neg     = bdx_neg_q;
    side_c_d.dy_neg     = bdy_neg_q;
    side_c_d.swap       = swap;
    side_c_d.small_zero = (ax_q == '0) || (ay_q == '0);
    side_c_d.diag       = ax_q == ay_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q     <= ax_q * ax_q;
      sqy_q     <= ay_q * ay_q;
      big_c_q   <= {{(slad_pkg::XyW-slad_pkg::DiffW){1'b0}}, (side_c_d.swap ? ay_q : ax_q)};
      small_c_q <= {{(slad_pkg::XyW-slad_pkg::DiffW){1'b0}}, (side_c_d.swap ? ax_q : ay_q)};
      side_c_q  <= side_c_d;
    end
  end

  // stage D: sum of squares, coarse normalize by 32, 16, 8
  always_ff @(posedge clk_i) begin
    logic [slad_pkg::XyW-1:0] b, s;
    if (adv) begin
      b = big_c_q;
      s = small_c_q;
      if (b < (64'd1 << 29)) begin b = b << 32; s = s << 32; end
      if (b < (64'd1 << 45)) begin b = b << 16; s = s << 16; end
      if (b < (64'd1 << 53)) begin b = b << 8;  s = s << 8;  end
      sum_q     <= sqx_q + sqy_q;
      big_d_q   <= b;
      small_d_q <= s;
      side_d_q  <= side_c_q;
    end
  end

  // stage E: fine normalize by 4, 2, 1; seed the chain
  always_ff @(posedge clk_i) begin
    logic [slad_pkg::XyW-1:0] b, s;
    if (adv) begin
      b = big_d_q;
      s = small_d_q;
      if (b < (64'd1 << 57)) begin b = b << 4; s = s << 4; end
      if (b < (64'd1 << 59)) begin b = b << 2; s = s << 2; end
      if (b < (64'd1 << 60)) begin b = b << 1; s = s << 1; end
      x_q[0]    <= $signed(b);
      y_q[0]    <= $signed(s);
      rad_q[0]  <= {sum_q, {(2*slad_pkg::LenFrac){1'b0}}};
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_d_q;
    end
  end

  // iteration chain: one root digit per stage, rotator steps in the first stages
  for (genvar j = 0; j < NIt; j++) begin : g_it
    // rotator index, held in range for the stages past the rotator
    localparam int unsigned RotIdx = (j < NCo) ? j : 0;

    logic [slad_pkg::RemW-1:0]  rem_d;
    logic [slad_pkg::RootW-1:0] root_d;
    slad_pkg::side_t            side_d;

    slad_sqrt_step u_sqrt (
      .rem_i  (rem_q[j]),
      .root_i (root_q[j]),
      .pair_i (rad_q[j][slad_pkg::RadW-1-2*j -: 2]),
      .rem_o  (rem_d),
      .root_o (root_d)
    );

    // angle bookkeeping carried in the side data
    always_comb begin
      logic signed [slad_pkg::ZW-1:0]   oct;
      logic signed [slad_pkg::A24W:0]   q;
      logic signed [slad_pkg::A24W:0]   a;
      logic [slad_pkg::A24W:0]          rs;
      side_d = side_q[j];
      oct = '0;
      q   = '0;
      a   = '0;
      rs  = '0;
      if (j < NCo) begin
        if (y_q[RotIdx] >= 0) begin
          side_d.z = side_q[j].z + slad_pkg::AtanTab[RotIdx];
        end else begin
          side_d.z = side_q[j].z - slad_pkg::AtanTab[RotIdx];
        end
      end else if (j == slad_pkg::OctStep) begin
        if (side_q[j].small_zero) begin
          oct = '0;
        end else if (side_q[j].diag) begin
          oct = slad_pkg::Deg45Z;
        end else if (side_q[j].z < 0) begin
          oct = '0;
        end else if (side_q[j].z > slad_pkg::Deg45Z) begin
          oct = slad_pkg::Deg45Z;
        end else begin
          oct = side_q[j].z;
        end
        q = side_q[j].swap ? (slad_pkg::Deg90W - oct) : {{2{oct[slad_pkg::ZW-1]}}, oct};
        side_d.a24 = q[slad_pkg::A24W-1:0];
      end else if (j == slad_pkg::QuadStep) begin
        q = $signed({1'b0, side_q[j].a24});
        if (!side_q[j].dx_neg && !side_q[j].dy_neg) begin
          a = q;
        end else if (side_q[j].dx_neg && !side_q[j].dy_neg) begin
          a = slad_pkg::Deg180W - q;
        end else if (side_q[j].dx_neg) begin
          a = slad_pkg::Deg180W + q;
        end else begin
          a = slad_pkg::Deg360W - q;
        end
        side_d.a24 = a[slad_pkg::A24W-1:0];
      end else if (j == slad_pkg::RoundStep) begin
        rs = {1'b0, side_q[j].a24} + slad_pkg::RoundHalf;
        if (side_q[j].same) begin
          side_d.ang = side_q[j].dx_neg ? slad_pkg::Half180 : '0;
        end else if (rs[slad_pkg::A24W:8] >= slad_pkg::Full360) begin
          side_d.ang = '0;
        end else begin
          side_d.ang = rs[slad_pkg::AngW+7:8];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        it_v_q[j+1] <= it_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad_q[j+1]  <= rad_q[j];
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
        side_q[j+1] <= side_d;
      end
    end

    // rotator step: for y >= 0 x += y>>j, y -= x>>j, else the opposite; drives y toward the x axis
    if (j < NCo) begin : g_rot
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (y_q[j] >= 0) begin
            x_q[j+1] <= x_q[j] + (y_q[j] >>> j);
            y_q[j+1] <= y_q[j] - (x_q[j] >>> j);
          end else begin
            x_q[j+1] <= x_q[j] - (y_q[j] >>> j);
            y_q[j+1] <= y_q[j] + (x_q[j] >>> j);
          end
        end
      end
    end
  end

  // output stage: direction decode and result register
  logic [8:0]                ip;
  logic [slad_pkg::DirW-1:0] dir_d;

  assign ip = side_q[NIt].ang[slad_pkg::AngW-1:slad_pkg::AngFrac];

  always_comb begin
    unique case (ip)
      slad_pkg::Deg45:  dir_d = 3'd1;
      slad_pkg::Deg90:  dir_d = 3'd2;
      slad_pkg::Deg135: dir_d = 3'd3;
      slad_pkg::Deg180: dir_d = 3'd4;
      slad_pkg::Deg225: dir_d = 3'd5;
      slad_pkg::Deg270: dir_d = 3'd6;
      slad_pkg::Deg315: dir_d = 3'd7;
      slad_pkg::Deg0:   dir_d = 3'd0;
      default:          dir_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= it_v_q[NIt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q  <= side_q[NIt].same ? '0 : root_q[NIt];
      ang_q  <= side_q[NIt].ang;
      dir_q  <= dir_d;
      same_q <= side_q[NIt].same;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.seg_length     = len_q;
  assign out_o.seg_angle      = ang_q;
  assign out_o.direction_code = dir_q;
  assign out_o.same_point     = same_q;

endmodule

### src/slad_sqrt_step.sv
// One restoring square-root digit: brings in two radicand bits, yields one root bit.
// Depends on slad_pkg for widths.
module slad_sqrt_step (
  input  logic [slad_pkg::RemW-1:0]  rem_i,
  input  logic [slad_pkg::RootW-1:0] root_i,
  input  logic [1:0]                 pair_i,
  output logic [slad_pkg::RemW-1:0]  rem_o,
  output logic [slad_pkg::RootW-1:0] root_o
);

  logic [slad_pkg::RemW+1:0] rem_n;
  logic [slad_pkg::RemW+1:0] trial;
  logic [slad_pkg::RemW+1:0] diff;
  logic                      ge;

  // trial divisor is 4*root+1
  assign rem_n  = {rem_i, pair_i};
  assign trial  = {2'b00, root_i, 2'b01};
  assign ge     = rem_n >= trial;
  assign diff   = rem_n - trial;
  assign rem_o  = ge ? diff[slad_pkg::RemW-1:0] : rem_n[slad_pkg::RemW-1:0];
  assign root_o = {root_i[slad_pkg::RootW-2:0], ge};

endmodule

### tb/segment_length_angle_direction_test.sv
// Self-checking testbench for segment_length_angle_direction: random and directed segments,
// predicted length/angle/direction compared in order with the results.
// Depends on slad_pkg, the slad channel interfaces and the block itself.
`timescale 1ns / 1ps

module segment_length_angle_direction_test;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic signed [slad_pkg::CoordW-1:0] hx, hy, tx, ty;
  } segment_t;

  typedef struct {
    logic [slad_pkg::LenW-1:0] len;
    logic [slad_pkg::AngW-1:0] ang;
    logic [slad_pkg::DirW-1:0] dir;
    logic                      same;
  } polar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slad_cfg_if cfg ();
  slad_seg_if seg ();
  slad_res_if res ();

  segment_length_angle_direction uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .in_i  (seg),
    .out_o (res)
  );

  always #6 clk_i = ~clk_i;

  segment_t    pending_segs[$];
  polar_t      expected_polar[$];
  logic [15:0] tol_shadow = '0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        seg_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  // exact floor of sqrt((ax^2 + ay^2) * 2^16)
  function automatic logic [slad_pkg::LenW-1:0] root_length(logic [32:0] ax, logic [32:0] ay);
    logic [95:0] rad;
    logic [97:0] rem;
    logic [97:0] trial;
    logic [47:0] root;
    rad = ((96'(ax) * 96'(ax)) + (96'(ay) * 96'(ay))) << 16;
    rem = '0;
    root = '0;
    for (int i = 47; i >= 0; i--) begin
      rem = (rem << 2) | 98'(rad[2*i +: 2]);
      trial = (98'(root) << 2) | 98'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root[slad_pkg::LenW-1:0];
  endfunction

  // first-octant vectoring rotation, 2^-24 degree units
  function automatic longint octant_deg(longint unsigned big, longint unsigned sml);
    logic signed [63:0] x, y, xs, ys, z;
    longint lim;
    lim = longint'(45) << 24;
    if (sml == 0) return 0;
    if (sml == big) return lim;
    while (big < (64'd1 << 60)) begin
      big = big << 1;
      sml = sml << 1;
    end
    x = big;
    y = sml;
    z = 0;
    for (int i = 0; i < slad_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + slad_pkg::AtanTab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - slad_pkg::AtanTab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > lim) z = lim;
    return z;
  endfunction

  function automatic polar_t predict_polar(segment_t s, logic [15:0] tol);
    polar_t p;
    longint dx, dy, q, a24;
    longint unsigned ax, ay, ang, ip, kdir;
    dx = longint'(s.tx) - longint'(s.hx);
    dy = longint'(s.ty) - longint'(s.hy);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    p.same = (ax <= tol) && (ay <= tol);
    p.len = '0;
    if (p.same) begin
      ang = dx < 0 ? (64'd180 << 16) : 0;
    end else begin
      p.len = root_length(ax[32:0], ay[32:0]);
      if (ay > ax) q = (longint'(90) << 24) - octant_deg(ay, ax);
      else q = octant_deg(ax, ay);
      if (dx >= 0 && dy >= 0) a24 = q;
      else if (dx < 0 && dy >= 0) a24 = (longint'(180) << 24) - q;
      else if (dx < 0) a24 = (longint'(180) << 24) + q;
      else a24 = (longint'(360) << 24) - q;
      ang = (longint'(a24) + 128) >> 8;
      if (ang >= (64'd360 << 16)) ang = 0;
    end
    ip = ang >> 16;
    kdir = (ip % 45 == 0 && ip / 45 < 8) ? (ip / 45) : 0;
    p.dir = kdir[slad_pkg::DirW-1:0];
    p.ang = ang[slad_pkg::AngW-1:0];
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_seg(int hx, int hy, int tx, int ty);
    segment_t s;
    s.hx = hx; s.hy = hy; s.tx = tx; s.ty = ty;
    pending_segs = {pending_segs, s};
  endtask

  // random segment: full range, short, axis/diagonal or extreme coordinates
  task automatic push_random_seg();
    int hx, hy, d, ex, ey;
    hx = $urandom; hy = $urandom;
    case ($urandom_range(0, 3))
      0: push_seg(hx, hy, $urandom, $urandom);
      1: push_seg(hx, hy, hx + $urandom_range(0, 20) - 10, hy + $urandom_range(0, 20) - 10);
      2: begin
        d = $urandom_range(1, 100000);
        ex = ($urandom_range(0, 2) - 1) * d;
        ey = ($urandom_range(0, 2) - 1) * d;
        push_seg(hx, hy, hx + ex, hy + ey);
      end
      default: push_seg($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff, hy,
                        $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff, $urandom);
    endcase
  endtask

  // write the tolerance register with the block idle
  task automatic write_tolerance(logic [15:0] v);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.same_point_tolerance <= v;
    do @(posedge clk_i); while (!cfg.ready);
    tol_shadow = v;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // hold off until nothing is queued, offered or in flight
  task automatic drain();
    while (pending_segs.size() != 0 || seg.valid || expected_polar.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // segment driver
  always @(negedge clk_i) begin
    if (rst_ni && (!seg.valid || seg_taken)) begin
      if (send_gap > 0 || pending_segs.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        seg.valid <= 1'b0;
      end else begin
        segment_t s;
        s = pending_segs.pop_front();
        seg.valid <= 1'b1;
        seg.head_x <= s.hx; seg.head_y <= s.hy;
        seg.tail_x <= s.tx; seg.tail_y <= s.ty;
        send_gap <= pick_gap();
      end
    end
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      res.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      res.ready <= 1'b1;
      recv_gap <= pick_gap();
    end
  end

  // monitor: predict on input transfer, compare on result transfer
  always @(posedge clk_i) begin
    seg_taken <= seg.valid && seg.ready;
    if (seg.valid && seg.ready) begin
      segment_t s;
      s.hx = seg.head_x; s.hy = seg.head_y; s.tx = seg.tail_x; s.ty = seg.tail_y;
      expected_polar = {expected_polar, predict_polar(s, tol_shadow)};
    end
    if (res.valid && res.ready) begin
      if (expected_polar.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected result transfer");
      end else begin
        polar_t e;
        e = expected_polar.pop_front();
        if (res.seg_length !== e.len || res.seg_angle !== e.ang ||
            res.direction_code !== e.dir || res.same_point !== e.same) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: exp len=%0d ang=%0d dir=%0d same=%0d",
                      " got len=%0d ang=%0d dir=%0d same=%0d"},
                     e.len, e.ang, e.dir, e.same, res.seg_length, res.seg_angle,
                     res.direction_code, res.same_point);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((seg.valid && seg.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    seg.valid = 1'b0;
    seg.head_x = '0; seg.head_y = '0; seg.tail_x = '0; seg.tail_y = '0;
    cfg.valid = 1'b0;
    cfg.same_point_tolerance = '0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero tolerance: extremes, axes, diagonals, vertical, wrap to 360
    write_tolerance(16'd0);
    push_seg(0, 0, 0, 0);
    push_seg(5, 5, 5, 5);
    push_seg(-2147483648, -2147483648, 2147483647, 2147483647);
    push_seg(2147483647, 2147483647, -2147483648, -2147483648);
    push_seg(-2147483648, 2147483647, 2147483647, -2147483648);
    push_seg(0, 0, 10, 0);
    push_seg(0, 0, -10, 0);
    push_seg(0, 0, 0, 10);
    push_seg(0, 0, 0, -10);
    push_seg(0, 0, 7, 7);
    push_seg(0, 0, -7, 7);
    push_seg(0, 0, -7, -7);
    push_seg(0, 0, 7, -7);
    push_seg(-2147483648, 0, 2147483647, -1);
    push_seg(0, 0, 3, 4);
    push_seg(0, 0, 1, 0);
    push_seg(-1, -1, -1, -1);
    repeat (80) push_random_seg();
    drain();

    // widest tolerance: most short segments collapse
    write_tolerance(16'hffff);
    push_seg(0, 0, -65535, 65535);
    push_seg(0, 0, 65535, -65535);
    push_seg(0, 0, 65536, 0);
    push_seg(0, 0, -1, 0);
    repeat (100) push_random_seg();
    drain();

    write_tolerance(16'd5);
    push_seg(0, 0, -5, 5);
    push_seg(0, 0, -6, 0);
    push_seg(0, 0, 5, -6);
    repeat (110) push_random_seg();
    drain();

    write_tolerance(16'($urandom));
    repeat (110) push_random_seg();
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
